### design/cpu_operand_fetch_sequencer_core_assert.svh
// Assertion macros for the operand fetch sequencer checker.
`ifndef CPU_OPERAND_FETCH_SEQUENCER_CORE_ASSERT_SVH
`define CPU_OPERAND_FETCH_SEQUENCER_CORE_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define COFS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Condition holds in the cycle after the trigger.
`define COFS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/cofs_pkg.sv
// Shared types and constants of the operand fetch sequencer.
`default_nettype none

package cofs_pkg;

   // Action codes of an input transfer
   localparam logic ACT_START = 1'b0;
   localparam logic ACT_DATA  = 1'b1;

   // Result kinds
   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // Addressing modes
   localparam logic [4:0] MODE_IMP    = 5'd0;
   localparam logic [4:0] MODE_R      = 5'd1;
   localparam logic [4:0] MODE_R_R    = 5'd2;
   localparam logic [4:0] MODE_R_D8   = 5'd3;
   localparam logic [4:0] MODE_R_D16  = 5'd4;
   localparam logic [4:0] MODE_D16    = 5'd5;
   localparam logic [4:0] MODE_MR_R   = 5'd6;
   localparam logic [4:0] MODE_R_MR   = 5'd7;
   localparam logic [4:0] MODE_R_HLI  = 5'd8;
   localparam logic [4:0] MODE_R_HLD  = 5'd9;
   localparam logic [4:0] MODE_HLI_R  = 5'd10;
   localparam logic [4:0] MODE_HLD_R  = 5'd11;
   localparam logic [4:0] MODE_R_A8   = 5'd12;
   localparam logic [4:0] MODE_A8_R   = 5'd13;
   localparam logic [4:0] MODE_D8     = 5'd14;
   localparam logic [4:0] MODE_HL_SPR = 5'd15;
   localparam logic [4:0] MODE_A16_R  = 5'd16;
   localparam logic [4:0] MODE_D16_R  = 5'd17;
   localparam logic [4:0] MODE_MR_D8  = 5'd18;
   localparam logic [4:0] MODE_MR     = 5'd19;
   localparam logic [4:0] MODE_R_A16  = 5'd20;
   localparam logic [4:0] MODE_LAST   = MODE_R_A16;

   // High page for I/O accesses
   localparam logic [15:0] HIGH_PAGE = 16'hFF00;

   // Which bus read the sequencer waits for
   typedef enum logic [1:0] {
      PH_IDLE,
      PH_READ1,
      PH_READ2,
      PH_READ3
   } phase_type;

   typedef struct packed {
      logic        action;
      logic        inst_valid;
      logic [4:0]  mode;
      logic [15:0] reg1_value;
      logic [15:0] reg2_value;
      logic        reg1_is_c;
      logic [15:0] pc_in;
      logic [15:0] hl_in;
      logic [7:0]  bus_data;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] read_address;
      logic [15:0] fetched_value;
      logic [15:0] dest_address;
      logic        dest_in_memory;
      logic [15:0] pc_out;
      logic        hl_changed;
      logic [15:0] hl_out;
      logic [1:0]  bus_cycles;
   } rsp_type;

   // Sequencer state; held_hl bit 16 flags a changed HL
   typedef struct packed {
      phase_type   phase;
      logic [4:0]  held_mode;
      logic [7:0]  low_byte;
      logic [15:0] held_fetch;
      logic [15:0] held_dest;
      logic        held_dest_flag;
      logic [15:0] held_pc;
      logic [16:0] held_hl;
      logic [1:0]  read_count;
   } state_type;

endpackage

`default_nettype wire

### design/cofs_step.sv
// Next-state and result logic of the operand fetch sequencer for one transfer.
`default_nettype none

module cofs_step
   import cofs_pkg::*;
(
   input  wire req_type   req,
   input  wire state_type cur,
   output state_type      nxt,
   output logic           res_valid,
   output rsp_type        res
);

   logic        fin;
   logic        go;
   logic [15:0] addr;
   phase_type   go_phase;
   logic [15:0] word;
   logic [15:0] pc_next;
   logic [15:0] r2_page;
   logic [15:0] r1_page;

   assign word    = {req.bus_data, cur.low_byte};
   assign pc_next = cur.held_pc + 16'd1;
   assign r1_page = req.reg1_is_c ? (req.reg1_value | HIGH_PAGE) : req.reg1_value;
   assign r2_page = req.reg1_is_c ? (req.reg2_value | HIGH_PAGE) : req.reg2_value;

   always_comb begin
      nxt       = cur;
      res       = '0;
      res_valid = 1'b0;
      fin       = 1'b0;
      go        = 1'b0;
      addr      = '0;
      go_phase  = PH_IDLE;

      if (req.action == ACT_START) begin
         // Start a new fetch; any pending one is dropped
         nxt.held_mode      = req.mode;
         nxt.held_pc        = req.pc_in;
         nxt.held_hl        = {1'b0, req.hl_in};
         nxt.held_fetch     = '0;
         nxt.held_dest      = '0;
         nxt.held_dest_flag = 1'b0;
         nxt.low_byte       = '0;
         nxt.read_count     = '0;
         nxt.phase          = PH_IDLE;
         if (!req.inst_valid || req.mode > MODE_LAST) begin
            res_valid  = 1'b1;
            res.kind   = KIND_ERROR;
            res.pc_out = req.pc_in;
            res.hl_out = req.hl_in;
         end else begin
            unique case (req.mode)
               MODE_IMP: begin
                  fin = 1'b1;
               end
               MODE_R: begin
                  nxt.held_fetch = req.reg1_value;
                  fin            = 1'b1;
               end
               MODE_R_R: begin
                  nxt.held_fetch = req.reg2_value;
                  fin            = 1'b1;
               end
               MODE_MR_R: begin
                  nxt.held_fetch     = req.reg2_value;
                  nxt.held_dest      = r1_page;
                  nxt.held_dest_flag = 1'b1;
                  fin                = 1'b1;
               end
               MODE_R_MR: begin
                  go       = 1'b1;
                  addr     = r2_page;
                  go_phase = PH_READ1;
               end
               MODE_R_HLI: begin
                  nxt.held_hl = {1'b1, req.hl_in + 16'd1};
                  go          = 1'b1;
                  addr        = req.reg2_value;
                  go_phase    = PH_READ1;
               end
               MODE_R_HLD: begin
                  nxt.held_hl = {1'b1, req.hl_in - 16'd1};
                  go          = 1'b1;
                  addr        = req.reg2_value;
                  go_phase    = PH_READ1;
               end
               MODE_HLI_R: begin
                  nxt.held_fetch     = req.reg2_value;
                  nxt.held_dest      = req.reg1_value;
                  nxt.held_dest_flag = 1'b1;
                  nxt.held_hl        = {1'b1, req.hl_in + 16'd1};
                  fin                = 1'b1;
               end
               MODE_HLD_R: begin
                  nxt.held_fetch     = req.reg2_value;
                  nxt.held_dest      = req.reg1_value;
                  nxt.held_dest_flag = 1'b1;
                  nxt.held_hl        = {1'b1, req.hl_in - 16'd1};
                  fin                = 1'b1;
               end
               MODE_A8_R, MODE_A16_R, MODE_D16_R: begin
                  nxt.held_fetch     = req.reg2_value;
                  nxt.held_dest_flag = 1'b1;
                  go                 = 1'b1;
                  addr               = req.pc_in;
                  go_phase           = PH_READ1;
               end
               MODE_MR_D8: begin
                  nxt.held_dest      = req.reg1_value;
                  nxt.held_dest_flag = 1'b1;
                  go                 = 1'b1;
                  addr               = req.pc_in;
                  go_phase           = PH_READ1;
               end
               MODE_MR: begin
                  nxt.held_dest      = req.reg1_value;
                  nxt.held_dest_flag = 1'b1;
                  go                 = 1'b1;
                  addr               = req.reg1_value;
                  go_phase           = PH_READ1;
               end
               default: begin
                  // Immediate operands: first read at PC
                  go       = 1'b1;
                  addr     = req.pc_in;
                  go_phase = PH_READ1;
               end
            endcase
         end
      end else if (cur.phase != PH_IDLE) begin
         // Take a returned bus byte
         nxt.read_count = cur.read_count + 2'd1;
         unique case (cur.held_mode)
            MODE_R_D8, MODE_R_A8, MODE_D8, MODE_HL_SPR, MODE_MR_D8: begin
               nxt.held_fetch = {8'h00, req.bus_data};
               nxt.held_pc    = pc_next;
               fin            = 1'b1;
            end
            MODE_R_MR, MODE_R_HLI, MODE_R_HLD, MODE_MR: begin
               nxt.held_fetch = {8'h00, req.bus_data};
               fin            = 1'b1;
            end
            MODE_A8_R: begin
               nxt.held_dest = HIGH_PAGE | {8'h00, req.bus_data};
               nxt.held_pc   = pc_next;
               fin           = 1'b1;
            end
            MODE_R_D16, MODE_D16, MODE_A16_R, MODE_D16_R, MODE_R_A16: begin
               unique case (cur.phase)
                  PH_READ1: begin
                     nxt.low_byte = req.bus_data;
                     nxt.held_pc  = pc_next;
                     go           = 1'b1;
                     addr         = pc_next;
                     go_phase     = PH_READ2;
                  end
                  PH_READ2: begin
                     nxt.held_pc = pc_next;
                     if (cur.held_mode == MODE_A16_R || cur.held_mode == MODE_D16_R) begin
                        nxt.held_dest = word;
                        fin           = 1'b1;
                     end else if (cur.held_mode == MODE_R_A16) begin
                        go       = 1'b1;
                        addr     = word;
                        go_phase = PH_READ3;
                     end else begin
                        nxt.held_fetch = word;
                        fin            = 1'b1;
                     end
                  end
                  default: begin
                     nxt.held_fetch = {8'h00, req.bus_data};
                     fin            = 1'b1;
                  end
               endcase
            end
            default: begin
               nxt.phase = PH_IDLE;
            end
         endcase
      end

      // Close the fetch with a done result
      if (fin) begin
         nxt.phase          = PH_IDLE;
         res_valid          = 1'b1;
         res.kind           = KIND_DONE;
         res.fetched_value  = nxt.held_fetch;
         res.dest_address   = nxt.held_dest;
         res.dest_in_memory = nxt.held_dest_flag;
         res.pc_out         = nxt.held_pc;
         res.hl_changed     = nxt.held_hl[16];
         res.hl_out         = nxt.held_hl[15:0];
         res.bus_cycles     = nxt.read_count;
      end

      // Issue a bus read request
      if (go) begin
         nxt.phase        = go_phase;
         res_valid        = 1'b1;
         res.kind         = KIND_READ;
         res.read_address = addr;
      end
   end

endmodule

`default_nettype wire

### design/cofs_rsp_reg.sv
// Result register of the operand fetch sequencer with valid/ready output.
`default_nettype none

module cofs_rsp_reg
   import cofs_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire          load,
   input  wire rsp_type load_data,
   input  wire          rsp_ready,
   output logic         rsp_valid,
   output rsp_type      rsp_data,
   output logic         take
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;
   rsp_type data_in;

   // Register is free when empty or drained this cycle
   assign take     = !valid_ff || rsp_ready;
   assign valid_in = load ? 1'b1 : (valid_ff && !rsp_ready);
   assign data_in  = load ? load_data : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold payload until the next load
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

### design/cpu_operand_fetch_sequencer_core.sv
// Top level of the operand fetch sequencer.
// Usage:
//   The req_ channel carries start transfers (req_action 0) with mode, operand
//   registers, PC and HL, and returned bus bytes (req_action 1) in req_bus_data.
//   The rsp_ channel returns one result per transfer that produces one: a bus
//   read request (kind 0), a done result (kind 1) or an error (kind 2).
//   A bus byte that arrives while no fetch is pending gives no result.
//   A start while a fetch is pending drops the pending fetch.
// Timing and throughput:
//   A result is presented in the cycle after its transfer is accepted. One
//   transfer is accepted every cycle while no result stalls; the single result
//   register sets that figure; the sequencer state updates in the same cycle.
// Reset:
//   Synchronous active-high reset clears the sequencer to idle and empties
//   the result register.
// Stall:
//   While a result waits with rsp_ready low, req_ready is low and the result
//   holds; req_ready returns in the cycle the result is taken.
`default_nettype none

module cpu_operand_fetch_sequencer_core
   import cofs_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire         req_action,
   input  wire         req_inst_valid,
   input  wire  [4:0]  req_mode,
   input  wire  [15:0] req_reg1_value,
   input  wire  [15:0] req_reg2_value,
   input  wire         req_reg1_is_c,
   input  wire  [15:0] req_pc_in,
   input  wire  [15:0] req_hl_in,
   input  wire  [7:0]  req_bus_data,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_read_address,
   output logic [15:0] rsp_fetched_value,
   output logic [15:0] rsp_dest_address,
   output logic        rsp_dest_in_memory,
   output logic [15:0] rsp_pc_out,
   output logic        rsp_hl_changed,
   output logic [15:0] rsp_hl_out,
   output logic [1:0]  rsp_bus_cycles
);

   req_type   req;
   state_type state_ff;
   state_type state_in;
   state_type step_nxt;
   logic      step_valid;
   rsp_type   step_res;
   rsp_type   rsp_data;
   logic      take;
   logic      accept;

   assign req = '{
      action:     req_action,
      inst_valid: req_inst_valid,
      mode:       req_mode,
      reg1_value: req_reg1_value,
      reg2_value: req_reg2_value,
      reg1_is_c:  req_reg1_is_c,
      pc_in:      req_pc_in,
      hl_in:      req_hl_in,
      bus_data:   req_bus_data
   };

   assign req_ready = take;
   assign accept    = req_valid && take;

   cofs_step u_step (
      .req       (req),
      .cur       (state_ff),
      .nxt       (step_nxt),
      .res_valid (step_valid),
      .res       (step_res)
   );

   // Advance the sequencer on each accepted transfer
   assign state_in = accept ? step_nxt : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   cofs_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (accept && step_valid),
      .load_data (step_res),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .take      (take)
   );

   assign rsp_kind           = rsp_data.kind;
   assign rsp_read_address   = rsp_data.read_address;
   assign rsp_fetched_value  = rsp_data.fetched_value;
   assign rsp_dest_address   = rsp_data.dest_address;
   assign rsp_dest_in_memory = rsp_data.dest_in_memory;
   assign rsp_pc_out         = rsp_data.pc_out;
   assign rsp_hl_changed     = rsp_data.hl_changed;
   assign rsp_hl_out         = rsp_data.hl_out;
   assign rsp_bus_cycles     = rsp_data.bus_cycles;

endmodule

`default_nettype wire

### design/cofs_checker.sv
// Port-level checker of the operand fetch sequencer and its bind.
`default_nettype none

`include "cpu_operand_fetch_sequencer_core_assert.svh"

module cofs_checker
   import cofs_pkg::*;
(
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_ready,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [1:0]  rsp_kind,
   input wire [15:0] rsp_read_address,
   input wire [15:0] rsp_fetched_value,
   input wire [15:0] rsp_dest_address,
   input wire [15:0] rsp_pc_out,
   input wire [15:0] rsp_hl_out,
   input wire [1:0]  rsp_bus_cycles
);

   // Stalled result holds
   `COFS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_read_address) && $stable(rsp_pc_out), "stalled result changed")

   // No transfer accepted while the result register is blocked
   `COFS_ASSERT_NOW(a_req_blocked, rsp_valid && !rsp_ready, !req_ready, "transfer accepted while result stalled")

   // Read requests carry nothing but the address
   `COFS_ASSERT_NOW(a_read_clean, rsp_valid && rsp_kind == KIND_READ, rsp_fetched_value == 16'd0 && rsp_dest_address == 16'd0 && rsp_pc_out == 16'd0 && rsp_hl_out == 16'd0 && rsp_bus_cycles == 2'd0, "read request carries stray fields")

   // A new result follows an accepted transfer
   `COFS_ASSERT_NOW(a_rsp_cause, rsp_valid && !$past(rsp_valid), $past(req_valid && req_ready), "result without accepted transfer")

endmodule

bind cpu_operand_fetch_sequencer_core cofs_checker u_cofs_checker (.*);

`default_nettype wire
